/* sv/tli_pkg.sv */
// Shared types and constants for the table linear interpolator.
// Used by tli_divider and table_linear_interpolator; depends on nothing.
package tli_pkg;

	// Field widths fixed by the interface.
	localparam int BP_W   = 16;
	localparam int VAL_W  = 16;
	localparam int IDX_W  = 6;
	localparam int PTS_W  = 7;
	localparam int APB_W  = 32;

	// Divider geometry: a 34-bit dividend and a 17-bit divisor give a 17-bit quotient.
	localparam int DIV_N_W = 34;
	localparam int DIV_D_W = 17;
	localparam int DIV_Q_W = 17;
	localparam int DIV_C_W = 5;

	// Product of two 17-bit signed differences.
	localparam int PROD_W = 34;

	// Reset value of the point count register.
	localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(2);

	// Request codes.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [BP_W-1:0]         bp;
		logic signed [VAL_W-1:0] val;
	} tli_entry_t;

	// Request into the divider.
	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} tli_div_req_t;

	// Response from the divider.
	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} tli_div_rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST,
		S_SEARCH,
		S_CMP,
		S_RD0,
		S_RD1,
		S_MUL,
		S_PREP,
		S_DIV,
		S_FIN
	} tli_state_t;

endpackage

/* sv/tli_ram.sv */
// Generic simple dual-port RAM: one write port and one read port, registered read.
// Depends on nothing.
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/tli_divider.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on tli_pkg for its request and response types.
module tli_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tli_pkg::tli_div_req_t req,
	output tli_pkg::tli_div_rsp_t rsp
);

	localparam int QW = tli_pkg::DIV_Q_W;
	localparam int DW = tli_pkg::DIV_D_W;

	logic                          busy_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [tli_pkg::DIV_C_W-1:0]   cnt_q;
	logic [DW-1:0]                 rem_q;
	logic [QW-1:0]                 quo_q;
	logic [DW-1:0]                 den_q;
	logic [DW:0]                   trial;
	logic                          take;
	logic [DW:0]                   diff;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		take  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Control: run one iteration per quotient bit and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == tli_pkg::DIV_C_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tli_pkg::DIV_C_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - tli_pkg::DIV_C_W'(1);
				if (cnt_q == tli_pkg::DIV_C_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the upper dividend bits seed the remainder, the lower bits shift through.
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.divisor;
			rem_q <= req.dividend[tli_pkg::DIV_N_W-1:QW];
			quo_q <= req.dividend[QW-1:0];
			ovf_q <= req.dividend[tli_pkg::DIV_N_W-1:QW] >= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	// A quotient that does not fit reads as all ones; it saturates downstream.
	assign rsp.done     = done_q;
	assign rsp.quotient = ovf_q ? '1 : quo_q;

endmodule

/* sv/table_linear_interpolator.sv */
// Table linear interpolator: breakpoint table in RAM, binary search and interpolation.
// Depends on tli_pkg, tli_ram and tli_divider.
//
// Usage:
// Requests arrive on req_valid/req_stall. A load request (action = 0) writes
// breakpoint and point_value at point_index and gives no response. A query
// request (action = 1) gives one response on rsp_valid/rsp_stall carrying
// energy and beyond_table. A query beyond the last breakpoint in use goes
// straight to the response after the read of that breakpoint. Any other query
// runs a binary search, with a read state and a compare state per search step
// for the single RAM read port, two reads for the interval ends, the multiply,
// and the bit-serial divider. One request is worked on at a time; req_stall is
// low only while the sequencer is idle.
// A finished response sits in an output register, so the next request is taken
// while the receiver holds rsp_stall high; the sequencer waits only when a new
// response is ready and the old one is still held.
// The point count register (byte address 0) resets to 2; the table RAM is not
// cleared, so every entry a query touches must be loaded first. Reset empties
// the output register and returns the sequencer to idle.
module table_linear_interpolator #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                action,
	input  logic [tli_pkg::IDX_W-1:0]           point_index,
	input  logic [tli_pkg::BP_W-1:0]            breakpoint,
	input  logic signed [tli_pkg::VAL_W-1:0]    point_value,
	input  logic [tli_pkg::BP_W-1:0]            query_distance,
	// Response channel.
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [tli_pkg::VAL_W-1:0]    energy,
	output logic                                beyond_table,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [tli_pkg::APB_W-1:0]           pwdata,
	output logic [tli_pkg::APB_W-1:0]           prdata,
	output logic                                pready
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = ($clog2(MAX_POINTS + 1) > tli_pkg::PTS_W) ?
		$clog2(MAX_POINTS + 1) : tli_pkg::PTS_W;
	localparam int LW = (AW > tli_pkg::IDX_W) ? AW : tli_pkg::IDX_W;
	localparam int EW = $bits(tli_pkg::tli_entry_t);
	localparam int SW = tli_pkg::DIV_Q_W + 2;

	tli_pkg::tli_state_t   state_q, state_nx;

	logic [tli_pkg::PTS_W-1:0]          pts_q;
	logic [tli_pkg::BP_W-1:0]           r_q;
	logic [AW-1:0]                      lo_q, hi_q, mid_q;
	logic [tli_pkg::BP_W-1:0]           x0_q, x1_q;
	logic signed [tli_pkg::VAL_W-1:0]   v0_q, v1_q;
	logic signed [tli_pkg::PROD_W-1:0]  num_q;
	logic signed [tli_pkg::DIV_D_W-1:0] den_q;
	logic                               neg_q, flat_q, far_q;
	logic                               rsp_valid_q, beyond_q;
	logic signed [tli_pkg::VAL_W-1:0]   energy_q;

	logic                               req_fire, fin_fire;
	logic [CW-1:0]                      pts_wide, n_pts, n_m1;
	logic [AW-1:0]                      last_idx, mid_c;
	logic [LW-1:0]                      idx_wide;
	logic                               load_ok;
	logic                               more_steps;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr, ram_raddr;
	tli_pkg::tli_entry_t                wentry, rentry;
	logic [EW-1:0]                      ram_rdata;
	logic                               beyond_c, below_c, den_bad;
	logic signed [tli_pkg::DIV_D_W-1:0] den_c, dr_c, dv_c;
	logic signed [tli_pkg::PROD_W-1:0]  num_c, mag_c;
	tli_pkg::tli_div_req_t              div_req;
	tli_pkg::tli_div_rsp_t              div_rsp;
	logic [SW-1:0]                      step_mag;
	logic signed [SW-1:0]               step_c, sum_c;
	logic signed [tli_pkg::VAL_W-1:0]   sat_c;

	// Configuration register, always ready.
	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : tli_pkg::APB_W'(pts_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= tli_pkg::PTS_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			pts_q <= pwdata[tli_pkg::PTS_W-1:0];
		end
	end

	// Points in use, clamped to the legal range, and the last index in use.
	always_comb begin
		pts_wide = CW'(pts_q);
		if (pts_wide < CW'(2)) begin
			n_pts = CW'(2);
		end else if (pts_wide > CW'(MAX_POINTS)) begin
			n_pts = CW'(MAX_POINTS);
		end else begin
			n_pts = pts_wide;
		end
		n_m1     = n_pts - CW'(1);
		last_idx = n_m1[AW-1:0];
	end

	// Load address and range check.
	always_comb begin
		idx_wide = LW'(point_index);
		load_ok  = {1'b0, idx_wide} < (LW + 1)'(MAX_POINTS);
	end

	assign req_fire = req_valid && !req_stall;
	assign fin_fire = (state_q == tli_pkg::S_FIN) && (!rsp_valid_q || !rsp_stall);

	// Search step decisions.
	always_comb begin
		more_steps = {1'b0, hi_q} > ({1'b0, lo_q} + (AW + 1)'(1));
		mid_c      = lo_q + ((hi_q - lo_q) >> 1);
		rentry     = tli_pkg::tli_entry_t'(ram_rdata);
		beyond_c   = r_q > rentry.bp;
		below_c    = r_q < rentry.bp;
	end

	// Table memory: breakpoint and value share one entry.
	assign wentry.bp  = breakpoint;
	assign wentry.val = point_value;

	tli_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wentry),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tli_pkg::S_IDLE: begin
				if (req_fire && action == tli_pkg::ACT_QUERY) begin
					state_nx = tli_pkg::S_LAST;
				end
			end
			tli_pkg::S_LAST:   state_nx = beyond_c ? tli_pkg::S_FIN : tli_pkg::S_SEARCH;
			tli_pkg::S_SEARCH: state_nx = more_steps ? tli_pkg::S_CMP : tli_pkg::S_RD0;
			tli_pkg::S_CMP:    state_nx = tli_pkg::S_SEARCH;
			tli_pkg::S_RD0:    state_nx = tli_pkg::S_RD1;
			tli_pkg::S_RD1:    state_nx = tli_pkg::S_MUL;
			tli_pkg::S_MUL:    state_nx = tli_pkg::S_PREP;
			tli_pkg::S_PREP:   state_nx = den_bad ? tli_pkg::S_FIN : tli_pkg::S_DIV;
			tli_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_nx = tli_pkg::S_FIN;
				end
			end
			tli_pkg::S_FIN: begin
				if (fin_fire) begin
					state_nx = tli_pkg::S_IDLE;
				end
			end
			default: state_nx = tli_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: stall and RAM ports.
	always_comb begin
		req_stall     = 1'b1;
		ram_we        = 1'b0;
		ram_waddr     = idx_wide[AW-1:0];
		ram_raddr     = lo_q;
		unique case (state_q)
			tli_pkg::S_IDLE: begin
				req_stall = 1'b0;
				ram_we    = req_valid && action == tli_pkg::ACT_LOAD && load_ok;
				ram_raddr = last_idx;
			end
			tli_pkg::S_SEARCH: ram_raddr = more_steps ? mid_c : lo_q;
			tli_pkg::S_RD0:    ram_raddr = lo_q + AW'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tli_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Interval differences and their product.
	always_comb begin
		den_c = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
		dr_c  = $signed({1'b0, r_q}) - $signed({1'b0, x0_q});
		dv_c  = $signed({v1_q[tli_pkg::VAL_W-1], v1_q}) -
			$signed({v0_q[tli_pkg::VAL_W-1], v0_q});
		num_c = dv_c * dr_c;
	end

	// Divider request: (2*|num| + den) / (2*den) rounds half away from zero.
	always_comb begin
		den_bad          = den_q[tli_pkg::DIV_D_W-1] || (den_q == '0);
		div_req.start    = (state_q == tli_pkg::S_PREP) && !den_bad;
		mag_c            = num_q[tli_pkg::PROD_W-1] ? -num_q : num_q;
		div_req.dividend = {mag_c[tli_pkg::DIV_N_W-2:0], 1'b0} +
			tli_pkg::DIV_N_W'($unsigned(den_q));
		div_req.divisor  = {den_q[tli_pkg::DIV_D_W-2:0], 1'b0};
	end

	tli_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Final sum and saturation.
	always_comb begin
		step_mag = flat_q ? '0 : SW'(div_rsp.quotient);
		step_c   = neg_q ? -$signed(step_mag) : $signed(step_mag);
		sum_c    = SW'(v0_q) + step_c;
		if (sum_c > SW'(32767)) begin
			sat_c = 16'sh7fff;
		end else if (sum_c < -SW'(32768)) begin
			sat_c = -16'sh8000;
		end else begin
			sat_c = sum_c[tli_pkg::VAL_W-1:0];
		end
	end

	// Query datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			tli_pkg::S_IDLE: begin
				r_q  <= query_distance;
				lo_q <= '0;
				hi_q <= last_idx;
			end
			tli_pkg::S_LAST: far_q <= beyond_c;
			tli_pkg::S_SEARCH: mid_q <= mid_c;
			tli_pkg::S_CMP: begin
				if (below_c) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			tli_pkg::S_RD0: begin
				x0_q <= rentry.bp;
				v0_q <= rentry.val;
			end
			tli_pkg::S_RD1: begin
				x1_q <= rentry.bp;
				v1_q <= rentry.val;
			end
			tli_pkg::S_MUL: begin
				num_q <= num_c;
				den_q <= den_c;
			end
			tli_pkg::S_PREP: begin
				flat_q <= den_bad;
				neg_q  <= num_q[tli_pkg::PROD_W-1];
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a response until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			beyond_q <= far_q;
			energy_q <= far_q ? '0 : sat_c;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign energy       = energy_q;
	assign beyond_table = beyond_q;

	// A beyond-table response always carries zero.
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && beyond_table |-> energy == '0)
		else $error("beyond-table response with nonzero energy");

	// The search window never collapses.
	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tli_pkg::S_SEARCH |-> lo_q < hi_q)
		else $error("search window empty");

	// A query request starts with the read of the last breakpoint.
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && action == tli_pkg::ACT_QUERY |=> state_q == tli_pkg::S_LAST)
		else $error("query request did not start the search");

	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == tli_pkg::S_DIV)
		else $error("divider finished outside its wait state");

endmodule
